// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is asserted
`define GDT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define GDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/gdt_pkg.sv =====
`default_nettype none
package gdt_pkg;

  // Input modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Register indexes, taken from paddr[2]
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam int          DIST_W   = 7;
  localparam logic [6:0]  DIST_MAX = 7'd127;
  localparam logic [6:0]  DIM_RST  = 7'd64;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] row;
    logic [5:0] col;
    logic       cell_value;
  } in_word_t;

  typedef struct packed {
    logic [6:0] distance;
    logic       no_source_found;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_RUN,
    OP_READ,
    OP_NONE
  } op_e;

  // Classified command passed from front to back
  typedef struct packed {
    op_e        op;
    logic       in_range;
    logic [5:0] row;
    logic [5:0] col;
    logic       cell_value;
  } cmd_t;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_READ     = 11'b00000000010,
    S_CLEAR    = 11'b00000000100,
    S_SCAN_RD  = 11'b00000001000,
    S_SCAN_WR  = 11'b00000010000,
    S_SEED_END = 11'b00000100000,
    S_POP_RD   = 11'b00001000000,
    S_POP      = 11'b00010000000,
    S_NB_RD    = 11'b00100000000,
    S_NB_CHK   = 11'b01000000000,
    S_SPARE    = 11'b10000000000
  } state_e;

endpackage
`default_nettype wire

// ===== design/gdt_ram.sv =====
`default_nettype none
module gdt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, read one entry with a registered output
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/gdt_front.sv =====
`default_nettype none
module gdt_front
  import gdt_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  output logic          full_o,
  input  wire in_word_t in_word_i,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  wire logic     cmd_take_i
);

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       cls;
  logic       acc, take;

  // Classify the incoming word
  always_comb begin
    cls.row        = in_word_i.row;
    cls.col        = in_word_i.col;
    cls.cell_value = in_word_i.cell_value;
    cls.in_range   = (32'(in_word_i.row) < MAX_ROWS) && (32'(in_word_i.col) < MAX_COLS);
    case (in_word_i.mode)
      MODE_WRITE: cls.op = OP_WRITE;
      MODE_RUN:   cls.op = OP_RUN;
      MODE_READ:  cls.op = OP_READ;
      default:    cls.op = OP_NONE;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rp_q];
  assign acc         = push_i && !full_o;
  assign take        = cmd_take_i && cmd_valid_o;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (acc)  wp_q <= ~wp_q;
      if (take) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(acc) - 2'(take);
    end
  end

  // Hold classified words
  always_ff @(posedge clk_i) begin
    if (acc) begin
      mem_q[wp_q] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== design/gdt_back.sv =====
`default_nettype none
module gdt_back
  import gdt_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  input  wire cmd_t       cmd_i,
  output logic            cmd_take_o,
  input  wire logic [6:0] rows_i,
  input  wire logic [6:0] cols_i,
  output logic            empty_o,
  input  wire logic       pop_i,
  output out_word_t       out_word_o
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int QW    = RW + CW + DIST_W;

  function automatic logic [AW-1:0] cell_idx(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic              ran_q, ran_d, flag_q, flag_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  logic [RW-1:0]     r_q, r_d, cur_r_q, cur_r_d;
  logic [CW-1:0]     c_q, c_d, cur_c_q, cur_c_d;
  logic [DIST_W-1:0] cur_d_q, cur_d_d, nd;
  logic [1:0]        nb_q, nb_d;
  logic [AW:0]       head_q, head_d, tail_q, tail_d;
  logic [31:0]       nr, nc;

  // Memory ports
  logic              g_we, g_wd, g_rd, v_we, v_wd, v_rd, d_we, q_we;
  logic [AW-1:0]     g_wa, g_ra, v_wa, v_ra, d_wa, d_ra;
  logic [DIST_W-1:0] d_wd, d_rd;
  logic [QW-1:0]     q_wd, q_rd;

  // Neighbour under test
  logic              nb_ok;
  logic [RW-1:0]     nb_r;
  logic [CW-1:0]     nb_c;

  // Result queue
  out_word_t  out_mem_q [2];
  logic       owp_q, orp_q;
  logic [1:0] ocnt_q;
  logic       opush, otake;
  out_word_t  ores;

  // Clamp the area in use
  always_comb begin
    nr = 32'(rows_i);
    nc = 32'(cols_i);
    if (nr == 32'd0) nr = 32'd1;
    else if (nr > MAX_ROWS) nr = MAX_ROWS;
    if (nc == 32'd0) nc = 32'd1;
    else if (nc > MAX_COLS) nc = MAX_COLS;
  end

  assign nd = (cur_d_q == DIST_MAX) ? DIST_MAX : cur_d_q + 7'd1;

  // Pick the neighbour for the current step
  always_comb begin
    nb_r  = cur_r_q;
    nb_c  = cur_c_q;
    nb_ok = 1'b0;
    case (nb_q)
      2'd0: begin
        nb_ok = (cur_r_q != '0);
        nb_r  = cur_r_q - RW'(1);
      end
      2'd1: begin
        nb_ok = (32'(cur_r_q) + 32'd1 < nr);
        nb_r  = cur_r_q + RW'(1);
      end
      2'd2: begin
        nb_ok = (cur_c_q != '0);
        nb_c  = cur_c_q - CW'(1);
      end
      default: begin
        nb_ok = (32'(cur_c_q) + 32'd1 < nc);
        nb_c  = cur_c_q + CW'(1);
      end
    endcase
  end

  // Sequence commands and the search
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    ran_d   = ran_q;
    flag_d  = flag_q;
    sweep_d = sweep_q;
    r_d     = r_q;
    c_d     = c_q;
    cur_r_d = cur_r_q;
    cur_c_d = cur_c_q;
    cur_d_d = cur_d_q;
    nb_d    = nb_q;
    head_d  = head_q;
    tail_d  = tail_q;
    cmd_take_o = 1'b0;
    opush   = 1'b0;
    ores.distance        = '0;
    ores.no_source_found = flag_q;
    g_we = 1'b0;
    g_wa = cell_idx(RW'(cmd_i.row), CW'(cmd_i.col));
    g_wd = cmd_i.cell_value;
    g_ra = cell_idx(r_q, c_q);
    v_we = 1'b0;
    v_wa = sweep_q;
    v_wd = 1'b0;
    v_ra = cell_idx(nb_r, nb_c);
    d_we = 1'b0;
    d_wa = sweep_q;
    d_wd = '0;
    d_ra = cell_idx(RW'(cmd_i.row), CW'(cmd_i.col));
    q_we = 1'b0;
    q_wd = {r_q, c_q, {DIST_W{1'b0}}};

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && ocnt_q != 2'd2) begin
          cmd_take_o = 1'b1;
          cmd_d      = cmd_i;
          case (cmd_i.op)
            OP_WRITE: begin
              g_we  = cmd_i.in_range;
              opush = 1'b1;
            end
            OP_READ:  state_d = S_READ;
            OP_RUN: begin
              sweep_d = '0;
              state_d = S_CLEAR;
            end
            default:  opush = 1'b1;
          endcase
        end
      end
      S_READ: begin
        opush         = 1'b1;
        ores.distance = (ran_q && cmd_q.in_range) ? d_rd : '0;
        state_d       = S_IDLE;
      end
      S_CLEAR: begin
        v_we = 1'b1;
        d_we = 1'b1;
        if (32'(sweep_q) == CELLS - 1) begin
          r_d     = '0;
          c_d     = '0;
          head_d  = '0;
          tail_d  = '0;
          state_d = S_SCAN_RD;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end
      S_SCAN_RD: state_d = S_SCAN_WR;
      S_SCAN_WR: begin
        if (!g_rd) begin
          v_we   = 1'b1;
          v_wa   = cell_idx(r_q, c_q);
          v_wd   = 1'b1;
          q_we   = 1'b1;
          tail_d = tail_q + (AW+1)'(1);
        end
        state_d = S_SCAN_RD;
        if (32'(c_q) + 32'd1 == nc) begin
          c_d = '0;
          if (32'(r_q) + 32'd1 == nr) state_d = S_SEED_END;
          else r_d = r_q + RW'(1);
        end else begin
          c_d = c_q + CW'(1);
        end
      end
      S_SEED_END: begin
        flag_d  = (tail_q == '0);
        ran_d   = 1'b1;
        state_d = S_POP_RD;
      end
      S_POP_RD: begin
        if (head_q == tail_q) begin
          opush   = 1'b1;
          state_d = S_IDLE;
        end else begin
          head_d  = head_q + (AW+1)'(1);
          state_d = S_POP;
        end
      end
      S_POP: begin
        cur_r_d = q_rd[QW-1 -: RW];
        cur_c_d = q_rd[DIST_W +: CW];
        cur_d_d = q_rd[DIST_W-1:0];
        d_we    = 1'b1;
        d_wa    = cell_idx(q_rd[QW-1 -: RW], q_rd[DIST_W +: CW]);
        d_wd    = q_rd[DIST_W-1:0];
        nb_d    = 2'd0;
        state_d = S_NB_RD;
      end
      S_NB_RD: begin
        if (nb_ok) begin
          state_d = S_NB_CHK;
        end else if (nb_q == 2'd3) begin
          state_d = S_POP_RD;
        end else begin
          nb_d = nb_q + 2'd1;
        end
      end
      S_NB_CHK: begin
        if (!v_rd) begin
          v_we   = 1'b1;
          v_wa   = cell_idx(nb_r, nb_c);
          v_wd   = 1'b1;
          q_we   = 1'b1;
          q_wd   = {nb_r, nb_c, nd};
          tail_d = tail_q + (AW+1)'(1);
        end
        if (nb_q == 2'd3) begin
          state_d = S_POP_RD;
        end else begin
          nb_d    = nb_q + 2'd1;
          state_d = S_NB_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ran_q   <= 1'b0;
      flag_q  <= 1'b0;
      head_q  <= '0;
      tail_q  <= '0;
      sweep_q <= '0;
      r_q     <= '0;
      c_q     <= '0;
      nb_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      ran_q   <= ran_d;
      flag_q  <= flag_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      sweep_q <= sweep_d;
      r_q     <= r_d;
      c_q     <= c_d;
      nb_q    <= nb_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    cur_r_q <= cur_r_d;
    cur_c_q <= cur_c_d;
    cur_d_q <= cur_d_d;
  end

  gdt_ram #(.WIDTH(1), .DEPTH(CELLS)) u_grid (
    .clk_i, .we_i(g_we), .waddr_i(g_wa), .wdata_i(g_wd), .raddr_i(g_ra), .rdata_o(g_rd)
  );

  gdt_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd), .raddr_i(v_ra), .rdata_o(v_rd)
  );

  gdt_ram #(.WIDTH(DIST_W), .DEPTH(CELLS)) u_dist (
    .clk_i, .we_i(d_we), .waddr_i(d_wa), .wdata_i(d_wd), .raddr_i(d_ra), .rdata_o(d_rd)
  );

  gdt_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(tail_q[AW-1:0]), .wdata_i(q_wd),
    .raddr_i(head_q[AW-1:0]), .rdata_o(q_rd)
  );

  // Result queue: two words
  assign empty_o    = (ocnt_q == 2'd0);
  assign out_word_o = out_mem_q[orp_q];
  assign otake      = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= 1'b0;
      orp_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (opush) owp_q <= ~owp_q;
      if (otake) orp_q <= ~orp_q;
      ocnt_q <= ocnt_q + 2'(opush) - 2'(otake);
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      out_mem_q[owp_q] <= ores;
    end
  end

endmodule
`default_nettype wire

// ===== design/grid_distance_transform_bfs.sv =====
`default_nettype none
// Manhattan distance transform of a binary grid by multi-source breadth-first
// search. Write items load one grid bit, run items compute every distance,
// read items return one cell's distance; each item gives one result word. A
// run first clears the visited and distance memories over all
// MAX_ROWS*MAX_COLS cells, then seeds the search from the zero cells of the
// area in use, then takes each cell reached from the queue and checks its
// neighbours. Each memory has a registered read, which the search sequencer
// waits out before it uses the word read.
// No clearing pass follows reset: reads before the first run return 0.
module grid_distance_transform_bfs
  import gdt_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire in_word_t    in_word_i,
  output logic             empty,
  input  wire logic        pop,
  output out_word_t        out_word_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [6:0] rows_q, cols_q;
  logic       cfg_we;
  logic       cmd_valid, cmd_take;
  cmd_t       cmd;

  // Register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_COLS) ? 32'(cols_q) : 32'(rows_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_RST;
      cols_q <= DIM_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_ROWS) rows_q <= pwdata[6:0];
      else cols_q <= pwdata[6:0];
    end
  end

  gdt_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .in_word_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  gdt_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .rows_i(rows_q), .cols_i(cols_q), .empty_o(empty), .pop_i(pop), .out_word_o
  );

endmodule
`default_nettype wire

// ===== design/gdt_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module gdt_checker
  import gdt_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire out_word_t   out_word_o,
  input wire logic [31:0] prdata
);

  // No result words while reset holds
  `GDT_ASSERT_ALWAYS(a_empty_in_reset, clk_i, !rst_ni |-> empty, "result queue not empty in reset")

  // Registers read back seven bits only
  `GDT_ASSERT(a_prdata_narrow, clk_i, rst_ni, prdata[31:7] == 25'd0, "wide register read data")

  // A waiting word stays until taken
  `GDT_ASSERT(a_word_stays, clk_i, rst_ni, !empty && !pop |=> !empty, "result word dropped")

  // A waiting word holds its value
  `GDT_ASSERT(a_word_holds, clk_i, rst_ni, !empty && !pop |=> $stable(out_word_o), "result word changed")

endmodule

bind grid_distance_transform_bfs gdt_checker u_gdt_checker (.*);
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gdt_pkg::*;

  localparam int         ROWS_MAX   = 64;
  localparam int         COLS_MAX   = 64;
  localparam int         CELLS      = ROWS_MAX * COLS_MAX;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int         LIMIT      = 1500000;
  localparam int         SETTLE     = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_word_t    in_word_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_word_t   out_word_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grid_distance_transform_bfs u_dut (
    .clk_i, .rst_ni, .push, .full, .in_word_i, .empty, .pop, .out_word_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state of the block
  logic       cell_grid [CELLS];
  logic       seen      [CELLS];
  logic [6:0] dist_map  [CELLS];
  int         bfs_cell  [CELLS];
  int         bfs_dist  [CELLS];
  logic       src_absent;
  logic [6:0] rows_cfg;
  logic [6:0] cols_cfg;

  // Generator-side record of which cells have been loaded
  bit         loaded [CELLS];

  in_word_t  pending_words [$];
  out_word_t expected_words [$];
  int        errors = 0;
  int        cycles = 0;
  int        words_in = 0;
  int        words_out = 0;

  function automatic int clamp_dim(logic [6:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Multi-source search over the area in use
  function automatic void run_distance_search();
    int nr, nc, head, tail, idx, d, r, c;
    int nb [4];
    bit ok [4];
    nr = clamp_dim(rows_cfg, ROWS_MAX);
    nc = clamp_dim(cols_cfg, COLS_MAX);
    for (int i = 0; i < CELLS; i++) begin
      seen[i] = 1'b0;
      dist_map[i] = '0;
    end
    head = 0;
    tail = 0;
    for (int rr = 0; rr < nr; rr++)
      for (int cc = 0; cc < nc; cc++) begin
        idx = rr * COLS_MAX + cc;
        if (cell_grid[idx] == 1'b0) begin
          seen[idx] = 1'b1;
          bfs_cell[tail] = idx;
          bfs_dist[tail] = 0;
          tail++;
        end
      end
    src_absent = (tail == 0);
    while (head < tail) begin
      idx = bfs_cell[head];
      d = bfs_dist[head];
      head++;
      r = idx / COLS_MAX;
      c = idx % COLS_MAX;
      dist_map[idx] = d[6:0];
      nb[0] = idx - COLS_MAX; ok[0] = r > 0;
      nb[1] = idx + COLS_MAX; ok[1] = r + 1 < nr;
      nb[2] = idx - 1;        ok[2] = c > 0;
      nb[3] = idx + 1;        ok[3] = c + 1 < nc;
      for (int k = 0; k < 4; k++)
        if (ok[k] && !seen[nb[k]] && tail < CELLS) begin
          seen[nb[k]] = 1'b1;
          bfs_cell[tail] = nb[k];
          bfs_dist[tail] = (d + 1 > 127) ? 127 : d + 1;
          tail++;
        end
    end
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t o;
    int idx;
    idx = int'(w.row) * COLS_MAX + int'(w.col);
    o.distance = '0;
    case (w.mode)
      MODE_WRITE: cell_grid[idx] = w.cell_value;
      MODE_RUN:   run_distance_search();
      MODE_READ:  o.distance = dist_map[idx];
      default: ;
    endcase
    o.no_source_found = src_absent;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on word %0d: %s got %0d want %0d", words_out, what, got, want);
    errors++;
  endtask

  // Accept words on the input side and predict their results
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("** grid_distance_transform_bfs: FAILED **");
      $finish;
    end
    if (rst_ni && push && !full) begin
      expected_words.push_back(predict_word(pending_words.pop_front()));
      words_in++;
    end
  end

  // Check words leaving the block against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $display("unexpected result word %0d", words_out);
        errors++;
      end else begin
        out_word_t want;
        want = expected_words.pop_front();
        if (out_word_o.distance !== want.distance)
          report_mismatch("distance", out_word_o.distance, want.distance);
        if (out_word_o.no_source_found !== want.no_source_found)
          report_mismatch("no_source_found", out_word_o.no_source_found,
                          want.no_source_found);
      end
      words_out++;
    end
  end

  // Drive the input side, holding off now and then outside the quiet stretch
  always @(negedge clk_i) begin
    bit quiet;
    quiet = words_in >= 300 && words_in < 420;
    if (rst_ni && pending_words.size() > 0 && (quiet || $urandom_range(0, 99) >= 25)) begin
      push <= 1'b1;
      in_word_i <= pending_words[0];
    end else begin
      push <= 1'b0;
      in_word_i <= in_word_t'($urandom);
    end
  end

  // Drive pop, stalling now and then outside the quiet stretch
  always @(negedge clk_i) begin
    bit quiet;
    quiet = words_out >= 300 && words_out < 420;
    pop <= rst_ni && (quiet || $urandom_range(0, 99) >= 25);
  end

  task automatic add_word(logic [1:0] mode, int row, int col, logic val);
    in_word_t w;
    w.mode = mode;
    w.row = row[5:0];
    w.col = col[5:0];
    w.cell_value = val;
    if (mode == MODE_WRITE) loaded[row * COLS_MAX + col] = 1'b1;
    pending_words.push_back(w);
  endtask

  // Load any unloaded cell of the area in use, then queue a run
  task automatic add_run();
    int nr, nc;
    nr = clamp_dim(rows_cfg, ROWS_MAX);
    nc = clamp_dim(cols_cfg, COLS_MAX);
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        if (!loaded[r * COLS_MAX + c]) add_word(MODE_WRITE, r, c, $urandom_range(0, 1));
    add_word(MODE_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_write(logic idx, logic [6:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {25'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_ROWS) rows_cfg = val;
    else cols_cfg = val;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Fill a phase: load the area with a given zero density, run, then mix
  task automatic add_phase(int zero_pct, int count);
    int nr, nc, pick, r, c;
    nr = clamp_dim(rows_cfg, ROWS_MAX);
    nc = clamp_dim(cols_cfg, COLS_MAX);
    for (int rr = 0; rr < nr; rr++)
      for (int cc = 0; cc < nc; cc++)
        add_word(MODE_WRITE, rr, cc, $urandom_range(0, 99) >= zero_pct);
    add_run();
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, nr - 1);
        c = $urandom_range(0, nc - 1);
      end else begin
        r = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
      end
      if (pick < 38) add_word(MODE_WRITE, r, c, $urandom_range(0, 99) >= zero_pct);
      else if (pick < 46) add_run();
      else if (pick < 95) add_word(MODE_READ, r, c, $urandom_range(0, 1));
      else add_word(MODE_SPARE, r, c, $urandom_range(0, 1));
    end
  endtask

  initial begin
    logic [6:0] row_set [8] = '{7'd4, 7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd8, 7'd5};
    logic [6:0] col_set [8] = '{7'd4, 7'd64, 7'd1, 7'd3, 7'd1, 7'd0, 7'd8, 7'd7};
    for (int i = 0; i < CELLS; i++) begin
      cell_grid[i] = 1'b0;
      seen[i] = 1'b0;
      dist_map[i] = '0;
      loaded[i] = 1'b0;
    end
    src_absent = 1'b0;
    rows_cfg = DIM_RST;
    cols_cfg = DIM_RST;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corners, reads before any run, the unused mode
    add_word(MODE_READ, 0, 0, 1'b0);
    add_word(MODE_READ, 63, 63, 1'b1);
    add_word(MODE_WRITE, 63, 63, 1'b1);
    add_word(MODE_WRITE, 0, 0, 1'b0);
    add_word(MODE_WRITE, 63, 0, 1'b0);
    add_word(MODE_WRITE, 0, 63, 1'b1);
    add_word(MODE_SPARE, 63, 63, 1'b1);
    add_word(MODE_SPARE, 0, 0, 1'b0);
    add_word(MODE_READ, 42, 21, 1'b1);
    wait_idle();

    // Directed: no source in a small area, then one source appears
    reg_write(REG_ROWS, 7'd2);
    reg_write(REG_COLS, 7'd3);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 3; c++) add_word(MODE_WRITE, r, c, 1'b1);
    add_word(MODE_RUN, 0, 0, 1'b0);
    add_word(MODE_READ, 1, 2, 1'b0);
    add_word(MODE_WRITE, 1, 2, 1'b0);
    add_word(MODE_READ, 0, 0, 1'b0);
    add_word(MODE_RUN, 63, 63, 1'b1);
    add_word(MODE_READ, 0, 0, 1'b0);
    add_word(MODE_READ, 63, 63, 1'b0);
    wait_idle();

    // Random phases over several area settings, extremes included
    for (int p = 0; p < 8; p++) begin
      reg_write(REG_ROWS, row_set[p]);
      reg_write(REG_COLS, col_set[p]);
      add_phase((p == 5) ? 0 : $urandom_range(5, 60), 60);
      wait_idle();
    end

    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("** grid_distance_transform_bfs: PASSED **");
    end else begin
      $display("** grid_distance_transform_bfs: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
